@@ src/mmf_pkg.sv @@
// shared types, constants and controller/datapath structs for the motion magnitude filter
package mmf_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned EST_W    = 24;
  localparam int unsigned MG_W     = 12;
  localparam int unsigned AXES     = 3;

  // arithmetic constants
  localparam int unsigned EMA_SHIFT   = 5;       // moving average weight of 1/32
  localparam int unsigned Q_FRAC      = 8;       // gravity estimate fraction bits
  localparam int unsigned SQ_W        = 32;      // one squared residual
  localparam int unsigned ACC_W       = 34;      // sum of three squares
  localparam int unsigned ROOT_W      = 16;
  localparam int unsigned REM_W       = 18;
  localparam int unsigned ROOT_STEPS  = 16;
  localparam int unsigned PROD_W      = 26;
  localparam int unsigned MG_SCALE    = 1000;
  localparam int unsigned MG_ROUND    = 8192;
  localparam int unsigned MG_SHIFT    = 14;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EST,
    ST_SQ,
    ST_LOAD,
    ST_ROOT,
    ST_SCALE,
    ST_DONE
  } mmf_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       est_upd;
    logic       sq_en;
    logic       sq_first;
    logic [1:0] sq_sel;
    logic       root_load;
    logic       root_step;
    logic       scale_en;
    logic       out_load;
  } mmf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic root_last;
  } mmf_sts_t;

endpackage

@@ src/mmf_if.sv @@
// valid/ready channel interfaces for samples and results

// sample channel
interface mmf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mmf_pkg::SAMPLE_W-1:0] accel_x_raw;
  logic signed [mmf_pkg::SAMPLE_W-1:0] accel_y_raw;
  logic signed [mmf_pkg::SAMPLE_W-1:0] accel_z_raw;

  modport source (output valid, output accel_x_raw, output accel_y_raw,
                  output accel_z_raw, input ready);
  modport sink   (input valid, input accel_x_raw, input accel_y_raw,
                  input accel_z_raw, output ready);
endinterface

// result channel
interface mmf_out_if;
  logic                        valid;
  logic                        ready;
  logic [mmf_pkg::MG_W-1:0]    motion_milli_g;

  modport source (output valid, output motion_milli_g, input ready);
  modport sink   (input valid, input motion_milli_g, output ready);
endinterface

@@ src/mmf_ctrl.sv @@
// sequencing state machine and handshake control
module mmf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mmf_pkg::mmf_sts_t sts,
  output mmf_pkg::mmf_cmd_t cmd
);

  mmf_pkg::mmf_state_t state_r, state_nxt;
  logic [1:0]          sq_cnt_r, sq_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  // state and handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmf_pkg::ST_IDLE;
      sq_cnt_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    sq_cnt_nxt = sq_cnt_r;
    cmd        = '0;
    cmd.sq_sel = sq_cnt_r;
    in_ready   = 1'b0;
    // result beat taken clears the output register
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      mmf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = mmf_pkg::ST_EST;
        end
      end
      mmf_pkg::ST_EST: begin
        cmd.est_upd = 1'b1;
        sq_cnt_nxt  = 2'd0;
        state_nxt   = mmf_pkg::ST_SQ;
      end
      mmf_pkg::ST_SQ: begin
        // one axis squared per cycle through the shared multiplier
        cmd.sq_en    = 1'b1;
        cmd.sq_first = (sq_cnt_r == 2'd0);
        sq_cnt_nxt   = sq_cnt_r + 2'd1;
        if (sq_cnt_r == 2'(mmf_pkg::AXES - 1)) begin
          state_nxt = mmf_pkg::ST_LOAD;
        end
      end
      mmf_pkg::ST_LOAD: begin
        cmd.root_load = 1'b1;
        state_nxt     = mmf_pkg::ST_ROOT;
      end
      mmf_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = mmf_pkg::ST_SCALE;
        end
      end
      mmf_pkg::ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_nxt    = mmf_pkg::ST_DONE;
      end
      mmf_pkg::ST_DONE: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mmf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/mmf_datapath.sv @@
// gravity estimate, residual squares, bit-serial square root and milli-g scaling
module mmf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mmf_pkg::mmf_cmd_t                   cmd,
  output mmf_pkg::mmf_sts_t                   sts,
  input  logic signed [mmf_pkg::SAMPLE_W-1:0] accel_x_raw,
  input  logic signed [mmf_pkg::SAMPLE_W-1:0] accel_y_raw,
  input  logic signed [mmf_pkg::SAMPLE_W-1:0] accel_z_raw,
  output logic        [mmf_pkg::MG_W-1:0]     motion_milli_g
);

  localparam int unsigned DIFF_W = mmf_pkg::EST_W + 1;
  localparam int unsigned STEP_W = DIFF_W - mmf_pkg::EMA_SHIFT;
  localparam int unsigned RES_W  = mmf_pkg::SAMPLE_W + 1;

  logic signed [mmf_pkg::SAMPLE_W-1:0] samp_r [mmf_pkg::AXES];
  logic signed [mmf_pkg::EST_W-1:0]    est_r  [mmf_pkg::AXES];
  logic signed [mmf_pkg::EST_W-1:0]    est_nxt[mmf_pkg::AXES];
  logic                                loaded_r;

  logic [mmf_pkg::ACC_W-1:0]  acc_r;
  logic [mmf_pkg::SQ_W-1:0]   rad_r;
  logic [mmf_pkg::REM_W-1:0]  rem_r;
  logic [mmf_pkg::ROOT_W-1:0] root_r;
  logic [3:0]                 step_r;
  logic [mmf_pkg::PROD_W-1:0] prod_r;
  logic [mmf_pkg::MG_W-1:0]   mg_r;

  // sample capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      samp_r[0] <= accel_x_raw;
      samp_r[1] <= accel_y_raw;
      samp_r[2] <= accel_z_raw;
    end
  end

  // moving average step per axis, difference over 32 truncated toward zero
  for (genvar g = 0; g < mmf_pkg::AXES; g++) begin : g_axis
    logic signed [mmf_pkg::EST_W-1:0] target;
    logic signed [DIFF_W-1:0]         diff;
    logic signed [DIFF_W-1:0]         biased;
    logic signed [STEP_W-1:0]         step;

    always_comb begin
      target = {samp_r[g], {mmf_pkg::Q_FRAC{1'b0}}};
      diff   = DIFF_W'(target) - DIFF_W'(est_r[g]);
      biased = diff[DIFF_W-1] ? diff + DIFF_W'((1 << mmf_pkg::EMA_SHIFT) - 1) : diff;
      step   = biased[DIFF_W-1:mmf_pkg::EMA_SHIFT];
      if (loaded_r) begin
        est_nxt[g] = est_r[g] + mmf_pkg::EST_W'(step);
      end else begin
        est_nxt[g] = target;
      end
    end
  end

  // gravity estimate registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      for (int i = 0; i < mmf_pkg::AXES; i++) begin
        est_r[i] <= '0;
      end
    end else if (cmd.est_upd) begin
      loaded_r <= 1'b1;
      for (int i = 0; i < mmf_pkg::AXES; i++) begin
        est_r[i] <= est_nxt[i];
      end
    end
  end

  // residual of the selected axis against the floored gravity term, then squared
  logic signed [mmf_pkg::SAMPLE_W-1:0] samp_sel;
  logic signed [mmf_pkg::SAMPLE_W-1:0] grav_sel;
  logic signed [RES_W-1:0]             resid;
  logic signed [2*RES_W-1:0]           sq_full;
  logic [mmf_pkg::SQ_W-1:0]            sq;

  always_comb begin
    case (cmd.sq_sel)
      2'd0:    begin samp_sel = samp_r[0]; grav_sel = est_r[0][mmf_pkg::EST_W-1:mmf_pkg::Q_FRAC]; end
      2'd1:    begin samp_sel = samp_r[1]; grav_sel = est_r[1][mmf_pkg::EST_W-1:mmf_pkg::Q_FRAC]; end
      default: begin samp_sel = samp_r[2]; grav_sel = est_r[2][mmf_pkg::EST_W-1:mmf_pkg::Q_FRAC]; end
    endcase
    resid   = RES_W'(samp_sel) - RES_W'(grav_sel);
    sq_full = resid * resid;
    sq      = sq_full[mmf_pkg::SQ_W-1:0];
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      if (cmd.sq_first) begin
        acc_r <= mmf_pkg::ACC_W'(sq);
      end else begin
        acc_r <= acc_r + mmf_pkg::ACC_W'(sq);
      end
    end
  end

  // square root, one result bit per cycle
  logic [mmf_pkg::SQ_W-1:0]  rad_sat;
  logic [mmf_pkg::REM_W-1:0] rem_sh;
  logic [mmf_pkg::REM_W-1:0] trial;

  always_comb begin
    // sum at or above 2^32 clamps to all ones
    if (acc_r[mmf_pkg::ACC_W-1:mmf_pkg::SQ_W] != '0) begin
      rad_sat = '1;
    end else begin
      rad_sat = acc_r[mmf_pkg::SQ_W-1:0];
    end
    rem_sh = {rem_r[mmf_pkg::REM_W-3:0], rad_r[mmf_pkg::SQ_W-1 -: 2]};
    trial  = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rad_r  <= rad_sat;
      rem_r  <= '0;
      root_r <= '0;
      step_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[mmf_pkg::SQ_W-3:0], 2'b00};
      step_r <= step_r + 4'd1;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[mmf_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[mmf_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign sts.root_last = (step_r == 4'(mmf_pkg::ROOT_STEPS - 1));

  // scale to milli-g with rounding
  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      prod_r <= mmf_pkg::PROD_W'(root_r) * mmf_pkg::PROD_W'(mmf_pkg::MG_SCALE)
                + mmf_pkg::PROD_W'(mmf_pkg::MG_ROUND);
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mg_r <= prod_r[mmf_pkg::MG_SHIFT +: mmf_pkg::MG_W];
    end
  end

  assign motion_milli_g = mg_r;

endmodule

@@ src/motion_magnitude_filter.sv @@
// top level of the motion magnitude filter
//
// Each sample beat carries one signed three-axis accelerometer reading at
// 16384 counts per g and produces exactly one result beat: the magnitude of
// the acceleration with gravity removed, rounded to milli-g and limited to
// 0..4000. Gravity is tracked per axis by a 1/32 moving average in Q8 that
// is loaded directly by the first sample after reset, so the first result
// is always 0. After a sample is accepted, the controller updates the
// estimate, forms the squares of the three axes one after another through
// one shared multiplier, clamps the sum, runs the bit-serial square root,
// scales to milli-g and loads the output register once it is free. The
// next sample is taken as soon as the result sits in the output register,
// even while that result still waits to be taken.
module motion_magnitude_filter (
  input  logic       clk,
  input  logic       rst_n,
  mmf_in_if.sink     in_ch,
  mmf_out_if.source  out_ch
);

  mmf_pkg::mmf_cmd_t cmd;
  mmf_pkg::mmf_sts_t sts;

  // sequencing
  mmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic
  mmf_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .accel_x_raw    (in_ch.accel_x_raw),
    .accel_y_raw    (in_ch.accel_y_raw),
    .accel_z_raw    (in_ch.accel_z_raw),
    .motion_milli_g (out_ch.motion_milli_g)
  );

endmodule
